/* hw/rtl/sbs_pkg.sv */
// ----------------------------------------------------------------------------
// SipHash backend selector package
// Shared item types, cell counts, hash constants and register codes.
// ----------------------------------------------------------------------------
package sbs_pkg;

	localparam int unsigned MAX_SERVERS = 64;
	localparam int unsigned COUNT_W     = 7;
	localparam int unsigned IDX_W       = 6;

	// Two half rounds per cell pair: 6 compression rounds and 4 finalization rounds.
	localparam int unsigned ROUND_CELLS  = 20;
	localparam int unsigned ABSORB1_CELL = 4;
	localparam int unsigned ABSORB2_CELL = 8;
	localparam int unsigned FINAL_CELL   = 12;

	localparam int unsigned HASH_W    = 64;
	localparam int unsigned MOD_STEP  = 8;
	localparam int unsigned MOD_CELLS = HASH_W / MOD_STEP;

	localparam logic [63:0] SIP_C0       = 64'h736f6d6570736575;
	localparam logic [63:0] SIP_C1       = 64'h646f72616e646f6d;
	localparam logic [63:0] SIP_C2       = 64'h6c7967656e657261;
	localparam logic [63:0] SIP_C3       = 64'h7465646279746573;
	localparam logic [63:0] LEN_WORD     = 64'h1000000000000000;
	localparam logic [63:0] FINAL_XOR    = 64'h00000000000000ff;
	localparam logic [63:0] KEY_LOW_RST  = 64'hbebaadde00000000;
	localparam logic [63:0] KEY_HIGH_RST = 64'h0;
	localparam logic [COUNT_W-1:0] COUNT_RST = 7'd2;

	typedef enum logic [1:0] {
		CFG_KEY_LOW      = 2'd0,
		CFG_KEY_HIGH     = 2'd1,
		CFG_SERVER_COUNT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [63:0] addr_first_word;
		logic [63:0] addr_second_word;
	} addr_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] server_index;
		logic [63:0]      hash_value;
	} result_item_t;

	// Hash state plus the message words still needed further down the chain.
	typedef struct packed {
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
		logic [63:0] w0;
		logic [63:0] w1;
	} sbs_lane_t;

	// Remainder in progress, the hash bits still to consume, and the hash itself.
	typedef struct packed {
		logic [63:0]      hash;
		logic [63:0]      pend;
		logic [IDX_W-1:0] rem;
	} sbs_mod_t;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned s);
		return (x << s) | (x >> (64 - s));
	endfunction

endpackage

/* hw/rtl/sbs_round_cell.sv */
// ----------------------------------------------------------------------------
// SipHash half-round cell
// One registered half of a SipRound; the phase input picks which half.
// ----------------------------------------------------------------------------
module sbs_round_cell import sbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      phase,
	input  logic      up_valid,
	input  sbs_lane_t up_data,
	output logic      up_ready,
	output logic      dn_valid,
	output sbs_lane_t dn_data,
	input  logic      dn_ready
);

	logic        valid_q;
	sbs_lane_t   data_q;
	sbs_lane_t   nxt;
	logic [63:0] sum_a;
	logic [63:0] sum_b;

	always_comb begin
		nxt = up_data;
		if (!phase) begin
			sum_a  = up_data.v0 + up_data.v1;
			sum_b  = up_data.v2 + up_data.v3;
			nxt.v0 = rotl64(sum_a, 32);
			nxt.v1 = rotl64(up_data.v1, 13) ^ sum_a;
			nxt.v2 = sum_b;
			nxt.v3 = rotl64(up_data.v3, 16) ^ sum_b;
		end else begin
			sum_a  = up_data.v0 + up_data.v3;
			sum_b  = up_data.v2 + up_data.v1;
			nxt.v0 = sum_a;
			nxt.v3 = rotl64(up_data.v3, 21) ^ sum_a;
			nxt.v1 = rotl64(up_data.v1, 17) ^ sum_b;
			nxt.v2 = rotl64(sum_b, 32);
		end
	end

	// The cell takes a new item whenever it is empty or its item moves on.
	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

/* hw/rtl/sbs_mod_cell.sv */
// ----------------------------------------------------------------------------
// Remainder cell
// Folds the next few hash bits into a running remainder by the server count.
// ----------------------------------------------------------------------------
module sbs_mod_cell import sbs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [COUNT_W-1:0] divisor,
	input  logic               up_valid,
	input  sbs_mod_t           up_data,
	output logic               up_ready,
	output logic               dn_valid,
	output sbs_mod_t           dn_data,
	input  logic               dn_ready
);

	logic             valid_q;
	sbs_mod_t         data_q;
	sbs_mod_t         nxt;
	logic [IDX_W:0]   trial;
	logic [IDX_W-1:0] rem;

	// Restoring remainder, one bit per step, most significant bit first.
	always_comb begin
		rem   = up_data.rem;
		trial = '0;
		for (int i = 0; i < MOD_STEP; i++) begin
			trial = {rem, up_data.pend[HASH_W-1-i]};
			if (trial >= divisor) begin
				trial = trial - divisor;
			end
			rem = trial[IDX_W-1:0];
		end
		nxt      = up_data;
		nxt.pend = up_data.pend << MOD_STEP;
		nxt.rem  = rem;
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

/* hw/rtl/siphash_backend_selector.sv */
// ----------------------------------------------------------------------------
// SipHash backend selector
// Hashes a 16-byte source address with SipHash-2-4 and picks a server slot.
// ----------------------------------------------------------------------------
// Usage. An item on the addr channel carries the source address as two
// little-endian 64-bit words. It is taken at a clock edge where addr_valid
// is high and addr_stall is low. Each item yields exactly one item on the
// result channel: the 64-bit hash and the hash modulo the server count.
// The configuration channel writes the two key words and the server count;
// cfg_ready is always high, and writes belong to times when the block is idle.
// A server count of zero acts as one server, and counts above 64 act as 64.
// The chain is 20 half-round cells, then 8 remainder cells of 8 bits
// each. One item enters per cycle while addr_stall is low; the half-round
// adder in each cell sets the clock. A stall on the result side holds the
// last cell, and the hold reaches back through every occupied cell, so
// empty cells keep filling; addr_stall rises only once every cell is full.
// Reset empties every cell and loads the default key and a count of two.
// ----------------------------------------------------------------------------
module siphash_backend_selector import sbs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         addr_valid,
	output logic         addr_stall,
	input  addr_item_t   addr,
	output logic         result_valid,
	input  logic         result_stall,
	output result_item_t result,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	// Configuration registers.
	logic [63:0]        key_low_q;
	logic [63:0]        key_high_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] divisor;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= KEY_LOW_RST;
			key_high_q <= KEY_HIGH_RST;
			count_q    <= COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_KEY_LOW:      key_low_q  <= cfg_data;
				CFG_KEY_HIGH:     key_high_q <= cfg_data;
				CFG_SERVER_COUNT: count_q    <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective divisor: zero means one server, and the count saturates.
	always_comb begin
		if (count_q == '0) begin
			divisor = COUNT_W'(1);
		end else if (count_q > COUNT_W'(MAX_SERVERS)) begin
			divisor = COUNT_W'(MAX_SERVERS);
		end else begin
			divisor = count_q;
		end
	end

	// Hash chain. Message words are folded in on the wires between cells.
	sbs_lane_t lane_in  [ROUND_CELLS];
	sbs_lane_t lane_out [ROUND_CELLS];
	logic      rvalid   [ROUND_CELLS];
	logic      rready   [ROUND_CELLS];

	// Hash state before the first cell: key words mixed with the constants,
	// and the first address word absorbed into v3.
	always_comb begin
		lane_in[0].v0 = key_low_q ^ SIP_C0;
		lane_in[0].v1 = key_high_q ^ SIP_C1;
		lane_in[0].v2 = key_low_q ^ SIP_C2;
		lane_in[0].v3 = key_high_q ^ SIP_C3 ^ addr.addr_first_word;
		lane_in[0].w0 = addr.addr_first_word;
		lane_in[0].w1 = addr.addr_second_word;
	end

	assign addr_stall = !rready[0];

	// Cell boundaries that absorb a message word or start finalization.
	for (genvar c = 1; c < ROUND_CELLS; c++) begin : g_inject
		always_comb begin
			lane_in[c] = lane_out[c-1];
			if (c == ABSORB1_CELL) begin
				lane_in[c].v0 = lane_out[c-1].v0 ^ lane_out[c-1].w0;
				lane_in[c].v3 = lane_out[c-1].v3 ^ lane_out[c-1].w1;
			end else if (c == ABSORB2_CELL) begin
				lane_in[c].v0 = lane_out[c-1].v0 ^ lane_out[c-1].w1;
				lane_in[c].v3 = lane_out[c-1].v3 ^ LEN_WORD;
			end else if (c == FINAL_CELL) begin
				lane_in[c].v0 = lane_out[c-1].v0 ^ LEN_WORD;
				lane_in[c].v2 = lane_out[c-1].v2 ^ FINAL_XOR;
			end
		end
	end

	// Even cells run the first half of a SipRound, odd cells the second.
	sbs_mod_t mod_in  [MOD_CELLS];
	sbs_mod_t mod_out [MOD_CELLS];
	logic     mvalid  [MOD_CELLS];
	logic     mready  [MOD_CELLS];

	for (genvar c = 0; c < ROUND_CELLS; c++) begin : g_round
		logic up_valid;
		logic dn_ready;

		if (c == 0) begin : g_first
			assign up_valid = addr_valid;
		end else begin : g_next
			assign up_valid = rvalid[c-1];
		end

		if (c == ROUND_CELLS - 1) begin : g_last
			assign dn_ready = mready[0];
		end else begin : g_mid
			assign dn_ready = rready[c+1];
		end

		sbs_round_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.phase    (1'(c % 2)),
			.up_valid (up_valid),
			.up_data  (lane_in[c]),
			.up_ready (rready[c]),
			.dn_valid (rvalid[c]),
			.dn_data  (lane_out[c]),
			.dn_ready (dn_ready)
		);
	end

	// Remainder chain. The finished hash enters with an empty remainder.
	logic [63:0] hash_word;

	assign hash_word = lane_out[ROUND_CELLS-1].v0 ^ lane_out[ROUND_CELLS-1].v1
			^ lane_out[ROUND_CELLS-1].v2 ^ lane_out[ROUND_CELLS-1].v3;

	always_comb begin
		mod_in[0].hash = hash_word;
		mod_in[0].pend = hash_word;
		mod_in[0].rem  = '0;
	end

	for (genvar c = 0; c < MOD_CELLS; c++) begin : g_mod
		logic up_valid;
		logic dn_ready;

		if (c == 0) begin : g_first
			assign up_valid = rvalid[ROUND_CELLS-1];
		end else begin : g_next
			assign up_valid = mvalid[c-1];
			assign mod_in[c] = mod_out[c-1];
		end

		if (c == MOD_CELLS - 1) begin : g_last
			assign dn_ready = !result_stall;
		end else begin : g_mid
			assign dn_ready = mready[c+1];
		end

		sbs_mod_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.divisor  (divisor),
			.up_valid (up_valid),
			.up_data  (mod_in[c]),
			.up_ready (mready[c]),
			.dn_valid (mvalid[c]),
			.dn_data  (mod_out[c]),
			.dn_ready (dn_ready)
		);
	end

	// The last remainder cell doubles as the output register.
	assign result_valid        = mvalid[MOD_CELLS-1];
	assign result.server_index = mod_out[MOD_CELLS-1].rem;
	assign result.hash_value   = mod_out[MOD_CELLS-1].hash;

endmodule
